// File: sv/tiny_port_mcu_core_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tiny port MCU core
// Shared property forms used by the core's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TINY_PORT_MCU_CORE_TOP_ASSERT_SVH
`define TINY_PORT_MCU_CORE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tpm_pkg.sv
// ----------------------------------------------------------------------------
// Tiny port MCU core package
// Request kinds, instruction opcodes and the records passed between units.
// ----------------------------------------------------------------------------
package tpm_pkg;

    // Request kind carried in the input sideband.
    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_TICK    = 2'd1,
        OP_RESTART = 2'd2
    } tpm_op_t;

    // Instruction opcodes.
    localparam logic [7:0] INS_NOP     = 8'h00;
    localparam logic [7:0] INS_SETB    = 8'h01;
    localparam logic [7:0] INS_CLRB    = 8'h02;
    localparam logic [7:0] INS_SETDIR  = 8'h03;
    localparam logic [7:0] INS_INBIT   = 8'h04;
    localparam logic [7:0] INS_OUTPORT = 8'h05;
    localparam logic [7:0] INS_INPORT  = 8'h06;
    localparam logic [7:0] INS_MOVI    = 8'h10;
    localparam logic [7:0] INS_MOVR    = 8'h11;
    localparam logic [7:0] INS_ADDR    = 8'h20;
    localparam logic [7:0] INS_ADDI    = 8'h21;
    localparam logic [7:0] INS_JMP     = 8'h30;
    localparam logic [7:0] INS_JNZ     = 8'h31;
    localparam logic [7:0] INS_JZ      = 8'h32;
    localparam logic [7:0] INS_HALT    = 8'hFF;

    // Direction value after reset or restart: every pin driven.
    localparam logic [7:0] DIR_RESET = 8'hFF;

    // One input request.
    typedef struct packed {
        tpm_op_t     op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  pins0;
        logic [7:0]  pins1;
    } tpm_item_t;

    // Up to four instruction bytes fetched at the program counter.
    typedef struct packed {
        logic [7:0] opc;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } tpm_fetch_t;

    // Architectural state reported with every result.
    typedef struct packed {
        logic [15:0] pc;
        logic        halt;
        logic [7:0]  lat0;
        logic [7:0]  lat1;
        logic [7:0]  dir0;
        logic [7:0]  dir1;
    } tpm_arch_t;

    // Register file write.
    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } tpm_regwr_t;

endpackage

// File: sv/tiny_port_mcu_core_top.sv
// ----------------------------------------------------------------------------
// Tiny port MCU core, top level
// An 8-bit core with two 8-bit ports, driven one request at a time.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser selects a program byte write, a
// tick (one instruction) or a restart. Every request returns one result on
// the m_ stream with both port latches, both direction registers, the PC
// and the halt flag as they stand after that request.
// A request runs through three stages: program store read, register file
// read, execute. Its result enters the output register as it leaves execute.
// No request is taken while a tick or restart is in register read, or in
// execute without leaving: the next tick fetches at the PC that the
// execute stage is producing, and the register file read for a tick sits
// between fetch and execute. Program writes go at one per cycle unless the
// output stalls or a tick or restart waits. After reset the program store
// is swept to zero, one row of the four banks per cycle, while s_tready
// stays low. A restart request keeps the program store.
// When m_tready is low the result waits in the output register; the two
// stages behind it hold at most two more requests, and s_tready stays low
// while they are full or while a tick or restart waits in them.
// ----------------------------------------------------------------------------
`include "tiny_port_mcu_core_top_assert.svh"

module tiny_port_mcu_core_top #(
    parameter int ROM_BYTES = 4096,
    parameter int REG_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // rom_addr[15:0], rom_data[23:16], pins_p0[31:24], pins_p1[39:32]
    input  logic [39:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // port0_value[7:0], port1_value[15:8], port0_dir[23:16], port1_dir[31:24],
    // prog_counter[47:32], is_halted[48], zero[55:49]
    output logic [55:0] m_tdata
);
    import tpm_pkg::*;

    tpm_item_t  in_item;
    tpm_item_t  s2_item_reg, s3_item_reg;
    logic       s2_vld_reg, s2_vld_next, s3_vld_reg, s3_vld_next;
    tpm_fetch_t s3_bytes_reg;
    tpm_arch_t  arch_reg, out_reg;
    logic       out_vld_reg, out_vld_next;

    logic       in_acc, s2_adv, s3_adv, s2_ctl, s3_ctl, hazard;
    logic [15:0] fetch_pc;
    logic       rom_busy;
    tpm_fetch_t rom_bytes;
    logic [7:0] rd_a, rd_b;
    tpm_arch_t  exec_nxt;
    tpm_regwr_t exec_wr, rf_wr;
    logic       exec_clr;

    // Unpack the request.
    assign in_item.op    = tpm_op_t'(s_tuser);
    assign in_item.addr  = s_tdata[15:0];
    assign in_item.data  = s_tdata[23:16];
    assign in_item.pins0 = s_tdata[31:24];
    assign in_item.pins1 = s_tdata[39:32];

    // Pipeline flow. Ticks and restarts change the PC, so a new request waits
    // while one sits in the register read stage, or in execute without leaving.
    assign s2_ctl   = (s2_item_reg.op == OP_TICK) || (s2_item_reg.op == OP_RESTART);
    assign s3_ctl   = (s3_item_reg.op == OP_TICK) || (s3_item_reg.op == OP_RESTART);
    assign s3_adv   = s3_vld_reg && (!out_vld_reg || m_tready);
    assign s2_adv   = s2_vld_reg && (!s3_vld_reg || s3_adv);
    assign hazard   = (s2_vld_reg && s2_ctl) || (s3_vld_reg && s3_ctl && !s3_adv);
    assign s_tready = !rom_busy && (!s2_vld_reg || s2_adv) && !hazard;
    assign in_acc   = s_tvalid && s_tready;

    // Fetch at the PC being written back this cycle when there is one.
    assign fetch_pc = (s3_adv && s3_ctl) ? exec_nxt.pc : arch_reg.pc;

    tpm_rom #(
        .ROM_BYTES (ROM_BYTES)
    ) u_rom (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc && (in_item.op == OP_TICK)),
        .rd_pc   (fetch_pc),
        .wr_en   (in_acc && (in_item.op == OP_WRITE)),
        .wr_addr (in_item.addr),
        .wr_data (in_item.data),
        .fetch   (rom_bytes),
        .busy    (rom_busy)
    );

    // Register write-back happens only as the execute stage retires.
    always_comb
    begin
        rf_wr    = exec_wr;
        rf_wr.en = exec_wr.en && s3_adv;
    end

    tpm_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (exec_clr && s3_adv),
        .rd_en     (s2_adv && (s2_item_reg.op == OP_TICK)),
        .rd_addr_a (rom_bytes.a),
        .rd_addr_b (rom_bytes.b),
        .wr        (rf_wr),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    tpm_exec #(
        .ROM_BYTES (ROM_BYTES),
        .REG_COUNT (REG_COUNT)
    ) u_exec (
        .item  (s3_item_reg),
        .fetch (s3_bytes_reg),
        .st    (arch_reg),
        .rd_a  (rd_a),
        .rd_b  (rd_b),
        .nxt   (exec_nxt),
        .wr    (exec_wr),
        .clr   (exec_clr)
    );

    // Stage valid flags.
    always_comb
    begin
        s2_vld_next  = in_acc ? 1'b1 : (s2_adv ? 1'b0 : s2_vld_reg);
        s3_vld_next  = s2_adv ? 1'b1 : (s3_adv ? 1'b0 : s3_vld_reg);
        out_vld_next = s3_adv ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            arch_reg.pc   <= '0;
            arch_reg.halt <= 1'b0;
            arch_reg.lat0 <= 8'h00;
            arch_reg.lat1 <= 8'h00;
            arch_reg.dir0 <= DIR_RESET;
            arch_reg.dir1 <= DIR_RESET;
        end
        else
        begin
            s2_vld_reg  <= s2_vld_next;
            s3_vld_reg  <= s3_vld_next;
            out_vld_reg <= out_vld_next;
            if (s3_adv)
            begin
                arch_reg <= exec_nxt;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s2_item_reg <= in_item;
        end
        if (s2_adv)
        begin
            s3_item_reg  <= s2_item_reg;
            s3_bytes_reg <= rom_bytes;
        end
        if (s3_adv)
        begin
            out_reg <= exec_nxt;
        end
    end

    // Result.
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_reg.halt, out_reg.pc, out_reg.dir1, out_reg.dir0,
                       out_reg.lat1, out_reg.lat0};

    // Checks.
    `TPM_ASSERT_NOW(a_clear_blocks_input, rom_busy, !s_tready,
        "request accepted during program store clear")
    `TPM_ASSERT_NOW(a_one_ctl_in_flight, s2_vld_reg && s2_ctl, !(s3_vld_reg && s3_ctl),
        "two PC-changing requests in flight")
    `TPM_ASSERT_NEXT(a_halt_holds_pc,
        arch_reg.halt && !(s3_adv && (s3_item_reg.op == OP_RESTART)),
        $stable(arch_reg.pc), "PC moved while halted")
    `TPM_ASSERT_NEXT(a_result_lands, s3_adv,
        out_vld_reg && (out_reg == $past(exec_nxt)), "retired state not presented")

endmodule

// File: sv/tpm_rom.sv
// ----------------------------------------------------------------------------
// Program store
// Four byte-interleaved banks so that a single read returns the four bytes
// at the program counter. Cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module tpm_rom #(
    parameter int ROM_BYTES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [15:0]         rd_pc,
    input  logic                wr_en,
    input  logic [15:0]         wr_addr,
    input  logic [7:0]          wr_data,
    output tpm_pkg::tpm_fetch_t fetch,
    output logic                busy
);
    import tpm_pkg::*;

    localparam int BANK_DEPTH = (ROM_BYTES + 3) / 4;
    localparam int ROW_W      = $clog2(BANK_DEPTH);
    localparam logic [16:0] ROM_LIMIT = 17'(ROM_BYTES);
    localparam logic [16:0] ROW_LIMIT = 17'(BANK_DEPTH);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(BANK_DEPTH - 1);

    logic [ROW_W-1:0] clr_row_reg, clr_row_next;
    logic             busy_reg, busy_next;
    logic [1:0]       lo_reg;
    logic [3:0]       inr_reg;
    logic [7:0]       q_reg [4];

    logic             wr_ok;
    logic [ROW_W-1:0] wr_row;
    logic [ROW_W-1:0] bank_row;
    logic [7:0]       bank_wdata;
    logic [3:0]       bank_we;
    logic [3:0]       rd_ok;
    logic [ROW_W-1:0] rd_row [4];
    logic [3:0]       inr_now;
    logic [7:0]       byte_k [4];

    // Clearing sweep, one row of every bank per cycle.
    always_comb
    begin
        clr_row_next = clr_row_reg;
        busy_next    = busy_reg;
        if (busy_reg)
        begin
            clr_row_next = clr_row_reg + ROW_W'(1);
            if (clr_row_reg == LAST_ROW)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_row_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else
        begin
            clr_row_reg <= clr_row_next;
            busy_reg    <= busy_next;
        end
    end

    assign busy = busy_reg;

    // Write port: the sweep has priority, writes beyond the store are dropped.
    assign wr_ok      = ({1'b0, wr_addr} < ROM_LIMIT);
    assign wr_row     = wr_addr[ROW_W+1:2];
    assign bank_row   = busy_reg ? clr_row_reg : wr_row;
    assign bank_wdata = busy_reg ? 8'h00 : wr_data;

    // Per-bank write enables, read rows and storage.
    for (genvar j = 0; j < 4; j++)
    begin : g_bank
        logic [1:0]  off;
        logic [16:0] sum;
        logic [7:0]  mem [BANK_DEPTH];

        assign bank_we[j] = busy_reg || (wr_en && wr_ok && (wr_addr[1:0] == 2'(j)));
        assign off        = 2'(j) - rd_pc[1:0];
        assign sum        = {1'b0, rd_pc} + {15'd0, off};
        assign rd_ok[j]   = ({2'b00, sum[16:2]} < ROW_LIMIT);
        assign rd_row[j]  = sum[ROW_W+1:2];
        assign inr_now[j] = (({1'b0, rd_pc} + 17'(j)) < ROM_LIMIT);

        always_ff @(posedge clk)
        begin
            if (bank_we[j])
            begin
                mem[bank_row] <= bank_wdata;
            end
            if (rd_en && rd_ok[j])
            begin
                q_reg[j] <= mem[rd_row[j]];
            end
        end
    end

    // Byte alignment and in-range flags captured with the read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg  <= '0;
            inr_reg <= '0;
        end
        else if (rd_en)
        begin
            lo_reg  <= rd_pc[1:0];
            inr_reg <= inr_now;
        end
    end

    // Rotate the bank outputs so that byte 0 is the opcode.
    always_comb
    begin
        case (lo_reg)
            2'd0:
            begin
                byte_k[0] = q_reg[0]; byte_k[1] = q_reg[1];
                byte_k[2] = q_reg[2]; byte_k[3] = q_reg[3];
            end
            2'd1:
            begin
                byte_k[0] = q_reg[1]; byte_k[1] = q_reg[2];
                byte_k[2] = q_reg[3]; byte_k[3] = q_reg[0];
            end
            2'd2:
            begin
                byte_k[0] = q_reg[2]; byte_k[1] = q_reg[3];
                byte_k[2] = q_reg[0]; byte_k[3] = q_reg[1];
            end
            default:
            begin
                byte_k[0] = q_reg[3]; byte_k[1] = q_reg[0];
                byte_k[2] = q_reg[1]; byte_k[3] = q_reg[2];
            end
        endcase
    end

    // Bytes past the end of the store read as zero.
    assign fetch.opc = inr_reg[0] ? byte_k[0] : 8'h00;
    assign fetch.a   = inr_reg[1] ? byte_k[1] : 8'h00;
    assign fetch.b   = inr_reg[2] ? byte_k[2] : 8'h00;
    assign fetch.c   = inr_reg[3] ? byte_k[3] : 8'h00;

endmodule

// File: sv/tpm_regfile.sv
// ----------------------------------------------------------------------------
// General purpose register file
// Synchronous memory with two read ports, per-entry valid bits for the
// restart clear, and a bypass for a write landing in the read cycle.
// ----------------------------------------------------------------------------
module tpm_regfile #(
    parameter int REG_COUNT = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clr,
    input  logic                rd_en,
    input  logic [7:0]          rd_addr_a,
    input  logic [7:0]          rd_addr_b,
    input  tpm_pkg::tpm_regwr_t wr,
    output logic [7:0]          rd_data_a,
    output logic [7:0]          rd_data_b
);
    import tpm_pkg::*;

    localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam logic [8:0] REG_LIMIT = 9'(REG_COUNT);

    logic [7:0]           mem [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg, vld_next;
    logic [7:0]           q_a_reg, q_b_reg, fwd_reg;
    logic                 live_a_reg, live_b_reg, hit_a_reg, hit_b_reg;

    logic [RW-1:0] ra, rb, wa;
    logic          ra_ok, rb_ok;

    assign ra    = rd_addr_a[RW-1:0];
    assign rb    = rd_addr_b[RW-1:0];
    assign wa    = wr.addr[RW-1:0];
    assign ra_ok = ({1'b0, rd_addr_a} < REG_LIMIT);
    assign rb_ok = ({1'b0, rd_addr_b} < REG_LIMIT);

    // Storage: written on an executed instruction, read for the next one.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wa] <= wr.data;
        end
        if (rd_en)
        begin
            q_a_reg <= mem[ra];
            q_b_reg <= mem[rb];
            fwd_reg <= wr.data;
        end
    end

    // Valid bits: a restart empties the file at once.
    always_comb
    begin
        vld_next = vld_reg;
        if (clr)
        begin
            vld_next = '0;
        end
        else if (wr.en)
        begin
            vld_next[wa] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            live_a_reg <= 1'b0;
            live_b_reg <= 1'b0;
            hit_a_reg  <= 1'b0;
            hit_b_reg  <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (rd_en)
            begin
                live_a_reg <= ra_ok && vld_reg[ra];
                live_b_reg <= rb_ok && vld_reg[rb];
                hit_a_reg  <= wr.en && (wr.addr == rd_addr_a);
                hit_b_reg  <= wr.en && (wr.addr == rd_addr_b);
            end
        end
    end

    // A same-cycle write wins; an entry never written reads as zero.
    assign rd_data_a = hit_a_reg ? fwd_reg : (live_a_reg ? q_a_reg : 8'h00);
    assign rd_data_b = hit_b_reg ? fwd_reg : (live_b_reg ? q_b_reg : 8'h00);

endmodule

// File: sv/tpm_exec.sv
// ----------------------------------------------------------------------------
// Instruction execute unit
// Works out the next architectural state and the register write for one
// request from the fetched bytes and the register operands.
// ----------------------------------------------------------------------------
module tpm_exec #(
    parameter int ROM_BYTES = 4096,
    parameter int REG_COUNT = 16
) (
    input  tpm_pkg::tpm_item_t  item,
    input  tpm_pkg::tpm_fetch_t fetch,
    input  tpm_pkg::tpm_arch_t  st,
    input  logic [7:0]          rd_a,
    input  logic [7:0]          rd_b,
    output tpm_pkg::tpm_arch_t  nxt,
    output tpm_pkg::tpm_regwr_t wr,
    output logic                clr
);
    import tpm_pkg::*;

    localparam logic [16:0] ROM_LIMIT = 17'(ROM_BYTES);
    localparam logic [8:0]  REG_LIMIT = 9'(REG_COUNT);

    logic        pc_ok, a_ok, b_ok, b_bit_ok, c_bit_ok, take;
    logic [15:0] pc_p1, pc_p3, pc_p4;
    logic [7:0]  mask_b, lv_b;

    // Operand checks and shared helpers.
    assign pc_ok    = ({1'b0, st.pc} < ROM_LIMIT);
    assign a_ok     = ({1'b0, fetch.a} < REG_LIMIT);
    assign b_ok     = ({1'b0, fetch.b} < REG_LIMIT);
    assign b_bit_ok = (fetch.b[7:3] == 5'd0);
    assign c_bit_ok = (fetch.c[7:3] == 5'd0);
    assign pc_p1    = st.pc + 16'd1;
    assign pc_p3    = st.pc + 16'd3;
    assign pc_p4    = st.pc + 16'd4;
    assign mask_b   = 8'd1 << fetch.b[2:0];
    assign lv_b     = (fetch.b == 8'd0) ? item.pins0 : item.pins1;
    assign take     = a_ok && ((fetch.opc == INS_JNZ) ? (rd_a != 8'd0) : (rd_a == 8'd0));

    // Next state for the request.
    always_comb
    begin
        nxt = st;
        wr  = '0;
        clr = 1'b0;
        case (item.op)
            OP_RESTART:
            begin
                nxt.pc   = '0;
                nxt.halt = 1'b0;
                nxt.lat0 = 8'h00;
                nxt.lat1 = 8'h00;
                nxt.dir0 = DIR_RESET;
                nxt.dir1 = DIR_RESET;
                clr      = 1'b1;
            end
            OP_TICK:
            begin
                if (!st.halt)
                begin
                    if (!pc_ok)
                    begin
                        nxt.halt = 1'b1;
                    end
                    else
                    begin
                        case (fetch.opc)
                            INS_NOP:
                            begin
                                nxt.pc = pc_p1;
                            end
                            INS_SETB, INS_CLRB:
                            begin
                                if (b_bit_ok)
                                begin
                                    if (fetch.a == 8'd0)
                                    begin
                                        nxt.lat0 = (fetch.opc == INS_SETB) ?
                                                   (st.lat0 | mask_b) : (st.lat0 & ~mask_b);
                                    end
                                    else
                                    begin
                                        nxt.lat1 = (fetch.opc == INS_SETB) ?
                                                   (st.lat1 | mask_b) : (st.lat1 & ~mask_b);
                                    end
                                end
                                nxt.pc = pc_p3;
                            end
                            INS_SETDIR:
                            begin
                                if (b_bit_ok)
                                begin
                                    if (fetch.a == 8'd0)
                                    begin
                                        nxt.dir0 = (fetch.c == 8'd0) ?
                                                   (st.dir0 & ~mask_b) : (st.dir0 | mask_b);
                                    end
                                    else
                                    begin
                                        nxt.dir1 = (fetch.c == 8'd0) ?
                                                   (st.dir1 & ~mask_b) : (st.dir1 | mask_b);
                                    end
                                end
                                nxt.pc = pc_p4;
                            end
                            INS_INBIT:
                            begin
                                wr.en   = a_ok && c_bit_ok;
                                wr.addr = fetch.a;
                                wr.data = {7'd0, lv_b[fetch.c[2:0]]};
                                nxt.pc  = pc_p4;
                            end
                            INS_OUTPORT:
                            begin
                                if (b_ok)
                                begin
                                    if (fetch.a == 8'd0)
                                    begin
                                        nxt.lat0 = rd_b;
                                    end
                                    else
                                    begin
                                        nxt.lat1 = rd_b;
                                    end
                                end
                                nxt.pc = pc_p3;
                            end
                            INS_INPORT:
                            begin
                                wr.en   = a_ok;
                                wr.addr = fetch.a;
                                wr.data = lv_b;
                                nxt.pc  = pc_p3;
                            end
                            INS_MOVI:
                            begin
                                wr.en   = a_ok;
                                wr.addr = fetch.a;
                                wr.data = fetch.b;
                                nxt.pc  = pc_p3;
                            end
                            INS_MOVR:
                            begin
                                wr.en   = a_ok && b_ok;
                                wr.addr = fetch.a;
                                wr.data = rd_b;
                                nxt.pc  = pc_p3;
                            end
                            INS_ADDR:
                            begin
                                wr.en   = a_ok && b_ok;
                                wr.addr = fetch.a;
                                wr.data = rd_a + rd_b;
                                nxt.pc  = pc_p3;
                            end
                            INS_ADDI:
                            begin
                                wr.en   = a_ok;
                                wr.addr = fetch.a;
                                wr.data = rd_a + fetch.b;
                                nxt.pc  = pc_p3;
                            end
                            INS_JMP:
                            begin
                                nxt.pc = {fetch.a, fetch.b};
                            end
                            INS_JNZ, INS_JZ:
                            begin
                                nxt.pc = take ? {fetch.b, fetch.c} : pc_p4;
                            end
                            INS_HALT:
                            begin
                                nxt.halt = 1'b1;
                            end
                            default:
                            begin
                                // Unknown opcodes stop the core.
                                nxt.halt = 1'b1;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                // Program writes and the unused kind leave the state alone.
                nxt = st;
            end
        endcase
    end

endmodule

// File: dv/tiny_port_mcu_core_top_test.sv
// ----------------------------------------------------------------------------
// Tiny port MCU core testbench
// A directed table of requests, then random programs loaded and
// run tick by tick. Each request is predicted from a shadow copy of the core
// state, and every result is compared field by field with the oldest
// prediction. Both stream sides idle at random, and the result side holds off
// for long stretches so that the core back-pressures its input.
// ----------------------------------------------------------------------------
module tiny_port_mcu_core_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tpm_pkg::*;

    localparam int ROM_BYTES       = 4096;
    localparam int REG_COUNT       = 16;
    localparam int RANDOM_ITEMS    = 1750;
    localparam int DIRECTED_ROWS   = 28;
    localparam int IDLE_LIMIT      = 5000;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int DRAIN_CYCLES    = 8;

    // Request code with no defined action, and an opcode the core does not know.
    localparam logic [1:0] OP_SPARE      = 2'd3;
    localparam logic [7:0] INS_UNDEFINED = 8'h7E;

    // Opcodes the program generator draws from, HALT apart.
    localparam logic [7:0] INSTR_SET [14] = '{
        INS_NOP, INS_SETB, INS_CLRB, INS_SETDIR, INS_INBIT, INS_OUTPORT, INS_INPORT,
        INS_MOVI, INS_MOVR, INS_ADDR, INS_ADDI, INS_JMP, INS_JNZ, INS_JZ
    };

    // One row of the directed table; want is used only where typed is set.
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  pins0;
        logic [7:0]  pins1;
        logic        typed;
        tpm_arch_t   want;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_WRITE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    // Shadow of the core: program store, register file and reported state.
    logic [7:0] shadow_rom [ROM_BYTES];
    logic [7:0] shadow_regs [REG_COUNT];
    tpm_arch_t  shadow_arch;

    // States the core should report, oldest first.
    tpm_arch_t  reported_state_q [$];
    logic [7:0] program_bytes [$];
    directed_row_t steps [DIRECTED_ROWS];

    int requests_sent    = 0;
    int results_seen     = 0;
    int error_count      = 0;
    int idle_cycles      = 0;
    int sender_gap_max   = 14;
    int receiver_gap_max = 14;

    tiny_port_mcu_core_top #(
        .ROM_BYTES(ROM_BYTES),
        .REG_COUNT(REG_COUNT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Ends the run when nothing has been accepted on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready)))
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tiny_port_mcu_core_top: mismatch");
                $finish;
            end
        end
        else
        begin
            idle_cycles = 0;
        end
    end

    task automatic report_error(input string msg);
        $display("%s", msg);
        error_count++;
    endtask

    // Operand byte at an offset from the PC; bytes past the store read as zero.
    function automatic logic [7:0] operand_at(input int unsigned offs);
        int unsigned a;
        a = shadow_arch.pc + offs;
        return (a < ROM_BYTES) ? shadow_rom[a] : 8'h00;
    endfunction

    // A restart clears everything but the program store.
    task automatic restart_shadow();
        shadow_arch = '{pc: 16'h0000, halt: 1'b0, lat0: 8'h00, lat1: 8'h00,
                        dir0: DIR_RESET, dir1: DIR_RESET};
        foreach (shadow_regs[i])
            shadow_regs[i] = 8'h00;
    endtask

    // Executes one instruction on the shadow state.
    task automatic execute_tick(input logic [7:0] pins0, input logic [7:0] pins1);
        logic [7:0] opc, a, b, c, mask, levels;
        logic       take;
        if (shadow_arch.halt)
        begin
            // A halted core ignores ticks.
        end
        else if (shadow_arch.pc >= ROM_BYTES)
        begin
            shadow_arch.halt = 1'b1;
        end
        else
        begin
            opc  = shadow_rom[shadow_arch.pc];
            a    = operand_at(1);
            b    = operand_at(2);
            c    = operand_at(3);
            mask = 8'h01 << b[2:0];
            case (opc)
                INS_NOP:
                    shadow_arch.pc += 16'd1;
                INS_SETB, INS_CLRB:
                begin
                    if (b < 8)
                    begin
                        if (a == 0)
                            shadow_arch.lat0 = (opc == INS_SETB) ?
                                (shadow_arch.lat0 | mask) : (shadow_arch.lat0 & ~mask);
                        else
                            shadow_arch.lat1 = (opc == INS_SETB) ?
                                (shadow_arch.lat1 | mask) : (shadow_arch.lat1 & ~mask);
                    end
                    shadow_arch.pc += 16'd3;
                end
                INS_SETDIR:
                begin
                    if (b < 8)
                    begin
                        if (a == 0)
                            shadow_arch.dir0 = (c == 0) ?
                                (shadow_arch.dir0 & ~mask) : (shadow_arch.dir0 | mask);
                        else
                            shadow_arch.dir1 = (c == 0) ?
                                (shadow_arch.dir1 & ~mask) : (shadow_arch.dir1 | mask);
                    end
                    shadow_arch.pc += 16'd4;
                end
                INS_INBIT:
                begin
                    if (a < REG_COUNT && c < 8)
                    begin
                        levels = (b == 0) ? pins0 : pins1;
                        shadow_regs[a] = {7'b0, levels[c[2:0]]};
                    end
                    shadow_arch.pc += 16'd4;
                end
                INS_OUTPORT:
                begin
                    if (b < REG_COUNT)
                    begin
                        if (a == 0)
                            shadow_arch.lat0 = shadow_regs[b];
                        else
                            shadow_arch.lat1 = shadow_regs[b];
                    end
                    shadow_arch.pc += 16'd3;
                end
                INS_INPORT:
                begin
                    if (a < REG_COUNT)
                        shadow_regs[a] = (b == 0) ? pins0 : pins1;
                    shadow_arch.pc += 16'd3;
                end
                INS_MOVI:
                begin
                    if (a < REG_COUNT)
                        shadow_regs[a] = b;
                    shadow_arch.pc += 16'd3;
                end
                INS_MOVR:
                begin
                    if (a < REG_COUNT && b < REG_COUNT)
                        shadow_regs[a] = shadow_regs[b];
                    shadow_arch.pc += 16'd3;
                end
                INS_ADDR:
                begin
                    if (a < REG_COUNT && b < REG_COUNT)
                        shadow_regs[a] = shadow_regs[a] + shadow_regs[b];
                    shadow_arch.pc += 16'd3;
                end
                INS_ADDI:
                begin
                    if (a < REG_COUNT)
                        shadow_regs[a] = shadow_regs[a] + b;
                    shadow_arch.pc += 16'd3;
                end
                INS_JMP:
                    shadow_arch.pc = {a, b};
                INS_JNZ, INS_JZ:
                begin
                    // A bad register operand never takes the branch.
                    take = 1'b0;
                    if (a < REG_COUNT)
                        take = (opc == INS_JNZ) ? (shadow_regs[a] != 0) : (shadow_regs[a] == 0);
                    if (take)
                        shadow_arch.pc = {b, c};
                    else
                        shadow_arch.pc += 16'd4;
                end
                // HALT and every unknown opcode stop the core where it stands.
                default:
                    shadow_arch.halt = 1'b1;
            endcase
        end
    endtask

    // Applies one request to the shadow and returns the state to be reported.
    task automatic apply_request(input logic [1:0] op, input logic [15:0] addr,
                                 input logic [7:0] data, input logic [7:0] pins0,
                                 input logic [7:0] pins1, output tpm_arch_t after);
        case (op)
            OP_WRITE:
                if (addr < ROM_BYTES)
                    shadow_rom[addr] = data;
            OP_TICK:
                execute_tick(pins0, pins1);
            OP_RESTART:
                restart_shadow();
            default:
                ;
        endcase
        after = shadow_arch;
    endtask

    // Offers one request after a random gap and predicts it once accepted.
    task automatic send_request(input logic [1:0] op, input logic [15:0] addr,
                                input logic [7:0] data, input logic [7:0] pins0,
                                input logic [7:0] pins1, input logic typed,
                                input tpm_arch_t want);
        int        gap;
        tpm_arch_t predicted;
        if (requests_sent % 64 == 0)
            sender_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
        gap = $urandom_range(0, sender_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pins1, pins0, data, addr};
        do
            @(posedge clk);
        while (!s_tready);
        apply_request(op, addr, data, pins0, pins1, predicted);
        reported_state_q.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    task automatic send_random_pins(input logic [1:0] op, input logic [15:0] addr,
                                    input logic [7:0] data);
        send_request(op, addr, data, 8'($urandom), 8'($urandom), 1'b0, '0);
    endtask

    task automatic write_byte(input int addr, input logic [7:0] data);
        send_random_pins(OP_WRITE, 16'(addr), data);
    endtask

    // Any request code with any field values.
    task automatic send_noise();
        send_random_pins(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                         8'($urandom_range(0, 255)));
    endtask

    // Operand pickers: mostly in range, now and then anything.
    function automatic logic [7:0] pick_reg();
        case ($urandom_range(0, 9))
            0:             return 8'($urandom_range(0, 255));
            1, 2, 3, 4, 5: return 8'($urandom_range(0, 3));
            default:       return 8'($urandom_range(0, REG_COUNT - 1));
        endcase
    endfunction

    function automatic logic [7:0] pick_bit();
        return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 7));
    endfunction

    function automatic logic [7:0] pick_port();
        case ($urandom_range(0, 9))
            0:       return 8'($urandom_range(0, 255));
            1, 2, 3: return 8'h00;
            default: return 8'($urandom_range(0, 1));
        endcase
    endfunction

    // Appends one instruction with random operands to program_bytes.
    task automatic append_instruction(input int base, input int span);
        logic [7:0]  opc;
        logic [15:0] target;
        case ($urandom_range(0, 31))
            0:       opc = INS_HALT;
            1:       opc = 8'($urandom_range(0, 255));
            default: opc = INSTR_SET[$urandom_range(0, 13)];
        endcase
        // Jumps mostly land inside the program, sometimes anywhere at all.
        if ($urandom_range(0, 7) == 0)
            target = 16'($urandom_range(0, 65535));
        else
            target = 16'(base + $urandom_range(0, span));
        program_bytes.push_back(opc);
        case (opc)
            INS_SETB, INS_CLRB:
            begin
                program_bytes.push_back(pick_port());
                program_bytes.push_back(pick_bit());
            end
            INS_SETDIR:
            begin
                program_bytes.push_back(pick_port());
                program_bytes.push_back(pick_bit());
                program_bytes.push_back($urandom_range(0, 1) ? 8'h00
                                                             : 8'($urandom_range(0, 255)));
            end
            INS_INBIT:
            begin
                program_bytes.push_back(pick_reg());
                program_bytes.push_back(pick_port());
                program_bytes.push_back(pick_bit());
            end
            INS_OUTPORT:
            begin
                program_bytes.push_back(pick_port());
                program_bytes.push_back(pick_reg());
            end
            INS_INPORT:
            begin
                program_bytes.push_back(pick_reg());
                program_bytes.push_back(pick_port());
            end
            INS_MOVI, INS_ADDI:
            begin
                program_bytes.push_back(pick_reg());
                program_bytes.push_back(8'($urandom_range(0, 255)));
            end
            INS_MOVR, INS_ADDR:
            begin
                program_bytes.push_back(pick_reg());
                program_bytes.push_back(pick_reg());
            end
            INS_JMP:
            begin
                program_bytes.push_back(target[15:8]);
                program_bytes.push_back(target[7:0]);
            end
            INS_JNZ, INS_JZ:
            begin
                program_bytes.push_back(pick_reg());
                program_bytes.push_back(target[15:8]);
                program_bytes.push_back(target[7:0]);
            end
            default:
                ;
        endcase
    endtask

    // Restart, load a short random program, then run it with some noise mixed in.
    task automatic run_episode();
        int          base, count, k, ticks;
        logic [15:0] hop;
        send_random_pins(OP_RESTART, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        case ($urandom_range(0, 5))
            0:       base = ROM_BYTES - $urandom_range(1, 24);
            1:       base = $urandom_range(16, ROM_BYTES - 64);
            default: base = 0;
        endcase
        // A program placed elsewhere is reached by a jump at address zero.
        if (base != 0)
        begin
            hop = 16'(base);
            write_byte(0, INS_JMP);
            write_byte(1, hop[15:8]);
            write_byte(2, hop[7:0]);
        end
        program_bytes.delete();
        count = $urandom_range(3, 14);
        for (k = 0; k < count; k++)
            append_instruction(base, 4 * count);
        if ($urandom_range(0, 2) == 0)
            program_bytes.push_back(INS_HALT);
        for (k = 0; k < program_bytes.size(); k++)
            write_byte(base + k, program_bytes[k]);
        ticks = $urandom_range(count, 3 * count);
        for (k = 0; k < ticks; k++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_noise();
            else
                send_random_pins(OP_TICK, 16'($urandom_range(0, 65535)),
                                 8'($urandom_range(0, 255)));
        end
    endtask

    // Compares one result with the oldest predicted state.
    task automatic check_result(input logic [55:0] word);
        tpm_arch_t want;
        if (reported_state_q.size() == 0)
        begin
            report_error($sformatf("result %0d arrived with no request outstanding",
                                   results_seen));
        end
        else
        begin
            want = reported_state_q.pop_front();
            if (word[7:0] !== want.lat0)
                report_error($sformatf("result %0d port0_value %h, expected %h",
                                       results_seen, word[7:0], want.lat0));
            if (word[15:8] !== want.lat1)
                report_error($sformatf("result %0d port1_value %h, expected %h",
                                       results_seen, word[15:8], want.lat1));
            if (word[23:16] !== want.dir0)
                report_error($sformatf("result %0d port0_dir %h, expected %h",
                                       results_seen, word[23:16], want.dir0));
            if (word[31:24] !== want.dir1)
                report_error($sformatf("result %0d port1_dir %h, expected %h",
                                       results_seen, word[31:24], want.dir1));
            if (word[47:32] !== want.pc)
                report_error($sformatf("result %0d prog_counter %h, expected %h",
                                       results_seen, word[47:32], want.pc));
            if (word[48] !== want.halt)
                report_error($sformatf("result %0d is_halted %b, expected %b",
                                       results_seen, word[48], want.halt));
            if (word[55:49] !== 7'd0)
                report_error($sformatf("result %0d padding %h, expected zero",
                                       results_seen, word[55:49]));
        end
        results_seen++;
    endtask

    // Result side: random stalls, with two long hold-offs to fill the core up.
    initial
    begin : result_sink
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_seen % 64 == 0)
                receiver_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
            gap = $urandom_range(0, receiver_gap_max);
            if (results_seen == 300 || results_seen == 1200)
                gap = HOLD_OFF_CYCLES;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            check_result(m_tdata);
        end
    end

    // Request side: reset, the directed table, then random programs.
    initial
    begin : request_source
        int i;
        steps = '{
            // A tick straight after reset finds a swept store: a NOP.
            '{OP_TICK,    16'h0000, 8'h00,   8'hFF, 8'h00, 1'b1,
              '{16'h0001, 1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF}},
            // The spare request code only reports the state.
            '{OP_SPARE,   16'hFFFF, 8'hFF,   8'h00, 8'hFF, 1'b1,
              '{16'h0001, 1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF}},
            '{OP_RESTART, 16'h0000, 8'h00,   8'h00, 8'h00, 1'b1,
              '{16'h0000, 1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF}},
            // Writes at and beyond the end of the store are dropped.
            '{OP_WRITE,   16'hFFFF, 8'hFF,   8'h00, 8'h00, 1'b1,
              '{16'h0000, 1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF}},
            '{OP_WRITE,   16'h1000, 8'hAA,   8'h00, 8'h00, 1'b1,
              '{16'h0000, 1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF}},
            // SETB in the last byte, with a jump to it at address zero.
            '{OP_WRITE,   16'h0FFF, INS_SETB, 8'h00, 8'h00, 1'b1,
              '{16'h0000, 1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF}},
            '{OP_WRITE,   16'h0000, INS_JMP, 8'h00, 8'h00, 1'b1,
              '{16'h0000, 1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF}},
            '{OP_WRITE,   16'h0001, 8'h0F,   8'h00, 8'h00, 1'b1,
              '{16'h0000, 1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF}},
            '{OP_WRITE,   16'h0002, 8'hFF,   8'h00, 8'h00, 1'b1,
              '{16'h0000, 1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF}},
            '{OP_TICK,    16'h0000, 8'h00,   8'h00, 8'h00, 1'b1,
              '{16'h0FFF, 1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF}},
            // Operands fetched past the end read as zero: port 0, bit 0.
            '{OP_TICK,    16'h0000, 8'h00,   8'hFF, 8'hFF, 1'b1,
              '{16'h1002, 1'b0, 8'h01, 8'h00, 8'hFF, 8'hFF}},
            // The PC now lies beyond the store, so the core halts.
            '{OP_TICK,    16'h0000, 8'h00,   8'h00, 8'h00, 1'b1,
              '{16'h1002, 1'b1, 8'h01, 8'h00, 8'hFF, 8'hFF}},
            '{OP_TICK,    16'hFFFF, 8'hFF,   8'hFF, 8'hFF, 1'b1,
              '{16'h1002, 1'b1, 8'h01, 8'h00, 8'hFF, 8'hFF}},
            '{OP_RESTART, 16'hFFFF, 8'hFF,   8'hFF, 8'hFF, 1'b1,
              '{16'h0000, 1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF}},
            // HALT keeps the PC where it is.
            '{OP_WRITE,   16'h0000, INS_HALT, 8'h00, 8'h00, 1'b1,
              '{16'h0000, 1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF}},
            '{OP_TICK,    16'h0000, 8'h00,   8'h00, 8'h00, 1'b1,
              '{16'h0000, 1'b1, 8'h00, 8'h00, 8'hFF, 8'hFF}},
            '{OP_RESTART, 16'h0000, 8'h00,   8'h00, 8'h00, 1'b1,
              '{16'h0000, 1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF}},
            // An unknown opcode halts just as HALT does.
            '{OP_WRITE,   16'h0000, INS_UNDEFINED, 8'h00, 8'h00, 1'b1,
              '{16'h0000, 1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF}},
            '{OP_TICK,    16'h0000, 8'h00,   8'h00, 8'h00, 1'b1,
              '{16'h0000, 1'b1, 8'h00, 8'h00, 8'hFF, 8'hFF}},
            '{OP_RESTART, 16'h0000, 8'h00,   8'h00, 8'h00, 1'b1,
              '{16'h0000, 1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF}},
            // Read port 1 into r0, then write r0 out to port 1.
            '{OP_WRITE,   16'h0000, INS_INPORT, 8'h00, 8'h00, 1'b0, '0},
            '{OP_WRITE,   16'h0001, 8'h00,   8'h00, 8'h00, 1'b0, '0},
            '{OP_WRITE,   16'h0002, 8'h01,   8'h00, 8'h00, 1'b0, '0},
            '{OP_TICK,    16'h0000, 8'h00,   8'h3C, 8'hA5, 1'b0, '0},
            '{OP_WRITE,   16'h0003, INS_OUTPORT, 8'h00, 8'h00, 1'b0, '0},
            '{OP_WRITE,   16'h0004, 8'h01,   8'h00, 8'h00, 1'b0, '0},
            '{OP_WRITE,   16'h0005, 8'h00,   8'h00, 8'h00, 1'b0, '0},
            '{OP_TICK,    16'h0000, 8'h00,   8'h00, 8'h00, 1'b0, '0}
        };

        // The core sweeps its store to zero after reset; the shadow starts clean.
        foreach (shadow_rom[k])
            shadow_rom[k] = 8'h00;
        restart_shadow();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++)
            send_request(steps[i].op, steps[i].addr, steps[i].data, steps[i].pins0,
                         steps[i].pins1, steps[i].typed, steps[i].want);

        while (requests_sent < DIRECTED_ROWS + RANDOM_ITEMS)
            run_episode();
        s_tvalid <= 1'b0;

        // Wait for every outstanding result, then idle on to catch stray results.
        while (reported_state_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tiny_port_mcu_core_top: match");
        else
            $display("tiny_port_mcu_core_top: mismatch");
        $finish;
    end

endmodule
